FILE: src/cgmig_pkg.sv
// ----------------------------------------------------------------------------
// Cube grid mesh index generator package
// Shared constants, register codes, derived mesh sizes and pipeline types.
// ----------------------------------------------------------------------------
`default_nettype none

package cgmig_pkg;

  localparam int MAX_SQUARES   = 64;
  localparam int RESET_SQUARES = 8;
  localparam logic [30:0] RESET_HALF_SIDE = 31'd37837;
  localparam logic [30:0] RESET_GRID_STEP = 31'd9459;

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_SQUARES   = 2'd0;
  localparam logic [1:0] REG_HALF_SIDE = 2'd1;
  localparam logic [1:0] REG_GRID_STEP = 2'd2;

  localparam logic ACT_VERTEX   = 1'b0;
  localparam logic ACT_TRIANGLE = 1'b1;

  localparam logic [1:0] SIDE_PX = 2'd0;
  localparam logic [1:0] SIDE_NZ = 2'd1;
  localparam logic [1:0] SIDE_NX = 2'd2;
  localparam logic [1:0] SIDE_PZ = 2'd3;

  // one quotient bit per divider stage
  localparam int DIV_STEPS = 7;
  localparam int ST_M1     = DIV_STEPS + 1;
  localparam int ST_M2     = DIV_STEPS + 2;
  localparam int ST_M3     = DIV_STEPS + 3;
  localparam int ST_OUT    = DIV_STEPS + 4;
  localparam int STAGES    = DIV_STEPS + 5;

  typedef struct packed {
    logic [6:0]  n;
    logic [5:0]  nm1;
    logic [7:0]  n3;
    logic [8:0]  n4;
    logic [14:0] ring;
    logic [14:0] ring_in;
    logic [14:0] vtot;
    logic [15:0] sides;
    logic [15:0] side_cov;
    logic [16:0] ttot;
    logic [14:0] base_bot;
    logic [14:0] rmn;
  } der_t;

  typedef struct packed {
    logic        act;
    logic        oor;
    logic        cov;
    logic        bot;
    logic [15:0] k;
    logic [6:0]  dvs;
    logic [15:0] rem;
    logic [6:0]  quo;
  } div_t;

  typedef struct packed {
    logic        act;
    logic        oor;
    logic        cov;
    logic        bot;
    logic        par;
    logic [6:0]  qq;
    logic [6:0]  rr;
    logic [1:0]  side;
    logic [6:0]  qv;
    logic [14:0] v1;
    logic [14:0] v4;
    logic [11:0] pr_lo;
    logic [11:0] pr_hi;
  } m1_t;

  typedef struct packed {
    logic        act;
    logic        oor;
    logic        cov;
    logic        bot;
    logic        par;
    logic        yneg;
    logic [6:0]  mx;
    logic [6:0]  my;
    logic [6:0]  mz;
    logic [14:0] c1;
    logic [14:0] c2;
    logic [14:0] c3;
    logic [14:0] c4;
  } m2_t;

  typedef struct packed {
    logic        act;
    logic        oor;
    logic        yneg;
    logic [37:0] px;
    logic [37:0] py;
    logic [37:0] pz;
    logic [14:0] a;
    logic [14:0] b;
    logic [14:0] c;
  } m3_t;

  function automatic der_t derive(input logic [6:0] sq);
    der_t        d;
    logic [6:0]  n;
    logic [5:0]  nm1;
    logic [12:0] nsq;
    logic [12:0] nn1;
    logic [11:0] inner;
    logic [14:0] ring;
    if (sq == 7'd0) begin
      n = 7'd1;
    end else if (sq > 7'(MAX_SQUARES)) begin
      n = 7'(MAX_SQUARES);
    end else begin
      n = sq;
    end
    nm1   = 6'(n - 7'd1);
    nsq   = {6'b0, n} * {6'b0, n};
    nn1   = {6'b0, n} * ({6'b0, n} + 13'd1);
    inner = {6'b0, nm1} * {6'b0, nm1};
    ring  = {nn1, 2'b00};
    d.n        = n;
    d.nm1      = nm1;
    d.n3       = {1'b0, n} + {n, 1'b0};
    d.n4       = {n, 2'b00};
    d.ring     = ring;
    d.ring_in  = ring + {3'b0, inner};
    d.vtot     = ring + {3'b0, inner} + {3'b0, inner};
    d.sides    = {nsq, 3'b000};
    d.side_cov = {nsq, 3'b000} + {2'b0, nsq, 1'b0};
    d.ttot     = {1'b0, nsq, 3'b000} + {2'b00, nsq, 2'b00};
    d.base_bot = {nsq, 2'b00};
    d.rmn      = ring - {8'b0, n};
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: src/cube_grid_mesh_index_generator_core.sv
// ----------------------------------------------------------------------------
// Cube grid mesh index generator
// Random-access vertex position and triangle index queries on a cube mesh
// with n grid squares per edge.
//
// Input stream: s_axis_tuser selects a vertex query (0) or a triangle query
// (1), s_axis_tdata carries the item number. Output stream: one result per
// request with Q16.16 position or three vertex indices in m_axis_tdata and
// the out-of-range flag in m_axis_tuser.
// The pipeline runs: classify, seven restoring divider stages (one
// quotient bit each, divisor n or n-1), two index mapping stages, position
// multiply, subtract/saturate into the output register. One request per
// cycle is taken at full rate; every stage holds a valid bit and bubbles
// collapse. When the receiver stalls, the output register holds its result
// and stages fill up behind it; s_axis_tready drops only when all are full.
// Reset clears all valid bits and loads squares 8, half side 37837 and
// grid step 9459. The APB registers are squares, half_side and grid_step
// at byte addresses 0, 4 and 8; pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_grid_mesh_index_generator_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [15:0]                  s_axis_tdata,  // item_index
  input  wire logic                         s_axis_tuser,  // action
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, zero pad
  output logic [143:0]                      m_axis_tdata,
  output logic                              m_axis_tuser,  // out_of_range
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [cgmig_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int NST = cgmig_pkg::STAGES;
  localparam int NDV = cgmig_pkg::DIV_STEPS;

  logic [6:0]        squares;
  logic [30:0]       half_side;
  logic [30:0]       grid_step;
  cgmig_pkg::der_t   der;

  logic [NST-1:0]    v;
  logic [NST:0]      en;

  cgmig_pkg::div_t   s0_next;
  cgmig_pkg::div_t   dv [NDV+1];
  cgmig_pkg::m1_t    m1, m1_next;
  cgmig_pkg::m2_t    m2, m2_next;
  cgmig_pkg::m3_t    m3, m3_next;

  logic [31:0]       pos_x, pos_y, pos_z;
  logic [14:0]       corner_a, corner_b, corner_c;
  logic              out_of_range;

  function automatic logic [14:0] cmap(input logic [6:0] r, input logic [6:0] c,
                                       input logic [11:0] pr, input logic bot,
                                       input cgmig_pkg::der_t d);
    logic [14:0] base;
    logic [14:0] first;
    logic [14:0] res;
    base  = bot ? d.base_bot : 15'd0;
    first = bot ? d.ring_in : d.ring;
    if (r == 7'd0) begin
      res = base + {8'b0, c};
    end else if (r >= d.n) begin
      res = bot ? d.rmn - {8'b0, c} : {7'b0, d.n3} - {8'b0, c};
    end else if (c == 7'd0) begin
      res = bot ? d.ring - {8'b0, r} : {6'b0, d.n4} - {8'b0, r};
    end else if (c >= d.n) begin
      res = base + {8'b0, d.n} + {8'b0, r};
    end else begin
      res = first + {3'b0, pr} + {8'b0, c} - 15'd1;
    end
    return res;
  endfunction

  function automatic logic [31:0] sat32(input logic [38:0] x);
    logic [31:0] res;
    if (x[38] && !(&x[37:31])) begin
      res = 32'h8000_0000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      squares   <= 7'(cgmig_pkg::RESET_SQUARES);
      der       <= cgmig_pkg::derive(7'(cgmig_pkg::RESET_SQUARES));
      half_side <= cgmig_pkg::RESET_HALF_SIDE;
      grid_step <= cgmig_pkg::RESET_GRID_STEP;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        cgmig_pkg::REG_SQUARES: begin
          squares <= pwdata[6:0];
          der     <= cgmig_pkg::derive(pwdata[6:0]);
        end
        cgmig_pkg::REG_HALF_SIDE: half_side <= pwdata[30:0];
        cgmig_pkg::REG_GRID_STEP: grid_step <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      cgmig_pkg::REG_SQUARES:   prdata = {25'b0, squares};
      cgmig_pkg::REG_HALF_SIDE: prdata = {1'b0, half_side};
      cgmig_pkg::REG_GRID_STEP: prdata = {1'b0, grid_step};
      default:                  prdata = 32'd0;
    endcase
  end

  // pipeline flow
  always_comb begin
    en[NST] = m_axis_tready;
    for (int i = NST - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // classify request, pick dividend and divisor
  logic [15:0] d_ring, d_rin, d_sid, d_scv;

  always_comb begin
    d_ring = s_axis_tdata - {1'b0, der.ring};
    d_rin  = s_axis_tdata - {1'b0, der.ring_in};
    d_sid  = s_axis_tdata - der.sides;
    d_scv  = s_axis_tdata - der.side_cov;
    s0_next.act = s_axis_tuser;
    s0_next.oor = 1'b0;
    s0_next.cov = 1'b0;
    s0_next.bot = 1'b0;
    s0_next.k   = s_axis_tdata;
    s0_next.dvs = der.n;
    s0_next.rem = 16'd0;
    s0_next.quo = 7'd0;
    if (s_axis_tuser == cgmig_pkg::ACT_VERTEX) begin
      if (s_axis_tdata < {1'b0, der.ring}) begin
        s0_next.rem = {2'b0, s_axis_tdata[15:2]};
      end else if (s_axis_tdata < {1'b0, der.ring_in}) begin
        s0_next.cov = 1'b1;
        s0_next.dvs = {1'b0, der.nm1};
        s0_next.rem = d_ring;
      end else if (s_axis_tdata < {1'b0, der.vtot}) begin
        s0_next.cov = 1'b1;
        s0_next.bot = 1'b1;
        s0_next.dvs = {1'b0, der.nm1};
        s0_next.rem = d_rin;
      end else begin
        s0_next.oor = 1'b1;
      end
    end else begin
      if (s_axis_tdata < der.sides) begin
        s0_next.rem = {3'b0, s_axis_tdata[15:3]};
      end else if (s_axis_tdata < der.side_cov) begin
        s0_next.cov = 1'b1;
        s0_next.rem = {1'b0, d_sid[15:1]};
      end else if ({1'b0, s_axis_tdata} < der.ttot) begin
        s0_next.cov = 1'b1;
        s0_next.bot = 1'b1;
        s0_next.rem = {1'b0, d_scv[15:1]};
      end else begin
        s0_next.oor = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dv[0] <= s0_next;
    end
  end

  // restoring divider, most significant quotient bit first
  for (genvar g = 1; g <= NDV; g++) begin : g_div
    localparam int B = NDV - g;
    cgmig_pkg::div_t nxt;
    logic [15:0]     sh;

    always_comb begin
      nxt = dv[g-1];
      sh  = 16'({9'b0, dv[g-1].dvs} << B);
      if (dv[g-1].rem >= sh) begin
        nxt.rem    = dv[g-1].rem - sh;
        nxt.quo[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        dv[g] <= nxt;
      end
    end
  end

  // split quotient and remainder into side, wrap and cover row products
  logic [8:0]  p9, sub9;
  logic [7:0]  jj;
  logic [15:0] q1;
  logic        wrap;
  logic [5:0]  rowm1;

  always_comb begin
    p9    = {1'b0, dv[NDV].rem[5:0], dv[NDV].k[1:0]};
    jj    = {dv[NDV].rem[5:0], dv[NDV].k[2:1]};
    q1    = {1'b0, dv[NDV].k[15:1]} + 16'd1;
    wrap  = ({1'b0, jj} == der.n4 - 9'd1);
    rowm1 = 6'(dv[NDV].quo - 7'd1);
    m1_next.act = dv[NDV].act;
    m1_next.oor = dv[NDV].oor;
    m1_next.cov = dv[NDV].cov;
    m1_next.bot = dv[NDV].bot;
    m1_next.par = dv[NDV].k[0];
    m1_next.qq  = dv[NDV].quo;
    m1_next.rr  = dv[NDV].rem[6:0];
    if (p9 < {2'b0, der.n}) begin
      m1_next.side = cgmig_pkg::SIDE_PX;
      sub9         = 9'd0;
    end else if (p9 < {1'b0, der.n, 1'b0}) begin
      m1_next.side = cgmig_pkg::SIDE_NZ;
      sub9         = {2'b0, der.n};
    end else if (p9 < {1'b0, der.n3}) begin
      m1_next.side = cgmig_pkg::SIDE_NX;
      sub9         = {1'b0, der.n, 1'b0};
    end else begin
      m1_next.side = cgmig_pkg::SIDE_PZ;
      sub9         = {1'b0, der.n3};
    end
    m1_next.qv    = 7'(p9 - sub9);
    m1_next.v1    = dv[NDV].k[15:1];
    m1_next.v4    = wrap ? 15'(q1 - {7'b0, der.n4}) : 15'(q1);
    m1_next.pr_lo = {6'b0, rowm1} * {6'b0, der.nm1};
    m1_next.pr_hi = {6'b0, dv[NDV].quo[5:0]} * {6'b0, der.nm1};
  end

  always_ff @(posedge clk) begin
    if (en[cgmig_pkg::ST_M1]) begin
      m1 <= m1_next;
    end
  end

  // grid multiples per axis, quad corner indices
  always_comb begin
    m2_next.act  = m1.act;
    m2_next.oor  = m1.oor;
    m2_next.cov  = m1.cov;
    m2_next.bot  = m1.bot;
    m2_next.par  = m1.par;
    m2_next.yneg = 1'b0;
    m2_next.mx   = 7'd0;
    m2_next.my   = 7'd0;
    m2_next.mz   = 7'd0;
    m2_next.c1   = 15'd0;
    m2_next.c2   = 15'd0;
    m2_next.c3   = 15'd0;
    m2_next.c4   = 15'd0;
    if (m1.act == cgmig_pkg::ACT_VERTEX) begin
      if (m1.cov) begin
        m2_next.mx   = m1.qq + 7'd1;
        m2_next.mz   = m1.rr + 7'd1;
        m2_next.yneg = m1.bot;
      end else begin
        m2_next.my = m1.qq;
        case (m1.side)
          cgmig_pkg::SIDE_PX: begin
            m2_next.mz = m1.qv;
          end
          cgmig_pkg::SIDE_NZ: begin
            m2_next.mx = m1.qv;
            m2_next.mz = der.n;
          end
          cgmig_pkg::SIDE_NX: begin
            m2_next.mx = der.n;
            m2_next.mz = der.n - m1.qv;
          end
          default: begin
            m2_next.mx = der.n - m1.qv;
          end
        endcase
      end
    end else begin
      if (m1.cov) begin
        m2_next.c1 = cmap(m1.qq, m1.rr, m1.pr_lo, m1.bot, der);
        m2_next.c2 = cmap(m1.qq, m1.rr + 7'd1, m1.pr_lo, m1.bot, der);
        m2_next.c3 = cmap(m1.qq + 7'd1, m1.rr, m1.pr_hi, m1.bot, der);
        m2_next.c4 = cmap(m1.qq + 7'd1, m1.rr + 7'd1, m1.pr_hi, m1.bot, der);
      end else begin
        m2_next.c1 = m1.v1;
        m2_next.c2 = m1.v1 + {6'b0, der.n4};
        m2_next.c3 = m1.v4 + {6'b0, der.n4};
        m2_next.c4 = m1.v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[cgmig_pkg::ST_M2]) begin
      m2 <= m2_next;
    end
  end

  // scale by grid step, order triangle corners
  always_comb begin
    m3_next.act  = m2.act;
    m3_next.oor  = m2.oor;
    m3_next.yneg = m2.yneg;
    m3_next.px   = 38'(m2.mx) * 38'(grid_step);
    m3_next.py   = 38'(m2.my) * 38'(grid_step);
    m3_next.pz   = 38'(m2.mz) * 38'(grid_step);
    if (!m2.cov) begin
      m3_next.a = m2.c1;
      m3_next.b = m2.par ? m2.c3 : m2.c2;
      m3_next.c = m2.par ? m2.c4 : m2.c3;
    end else if (!m2.bot) begin
      m3_next.a = m2.par ? m2.c2 : m2.c1;
      m3_next.b = m2.par ? m2.c4 : m2.c2;
      m3_next.c = m2.c3;
    end else begin
      m3_next.a = m2.c3;
      m3_next.b = m2.par ? m2.c4 : m2.c2;
      m3_next.c = m2.par ? m2.c2 : m2.c1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[cgmig_pkg::ST_M3]) begin
      m3 <= m3_next;
    end
  end

  // subtract from half side, saturate, zero the unused fields
  logic [38:0] h39, vx, vy, vz;
  logic [31:0] neg_h;

  always_comb begin
    h39   = {8'b0, half_side};
    vx    = h39 - {1'b0, m3.px};
    vy    = h39 - {1'b0, m3.py};
    vz    = h39 - {1'b0, m3.pz};
    neg_h = 32'd0 - {1'b0, half_side};
  end

  always_ff @(posedge clk) begin
    if (en[cgmig_pkg::ST_OUT]) begin
      out_of_range <= m3.oor;
      pos_x        <= 32'd0;
      pos_y        <= 32'd0;
      pos_z        <= 32'd0;
      corner_a     <= 15'd0;
      corner_b     <= 15'd0;
      corner_c     <= 15'd0;
      if (!m3.oor) begin
        if (m3.act == cgmig_pkg::ACT_VERTEX) begin
          pos_x <= sat32(vx);
          pos_y <= m3.yneg ? neg_h : sat32(vy);
          pos_z <= sat32(vz);
        end else begin
          corner_a <= m3.a;
          corner_b <= m3.b;
          corner_c <= m3.c;
        end
      end
    end
  end

  assign m_axis_tvalid = v[cgmig_pkg::ST_OUT];
  assign m_axis_tdata  = {3'b000, corner_c, corner_b, corner_a, pos_z, pos_y, pos_x};
  assign m_axis_tuser  = out_of_range;

endmodule

`default_nettype wire
